/* sv/lcasr_pkg.sv */
// Shared types and constants for the load cell converter serial reader.
// No dependencies; imported by load_cell_adc_serial_reader.
`default_nettype none

package lcasr_pkg;

   // one-hot sequencer codes
   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_WAIT = 4'b0010,
      PH_HIGH = 4'b0100,
      PH_LOW  = 4'b1000
   } phase_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TIMEOUT = 2'd1;
   localparam logic [1:0] ST_SAT     = 2'd2;

   localparam logic CSR_TIMEOUT_LIMIT = 1'b0;
   localparam logic CSR_HALF_PERIOD   = 1'b1;

   localparam int TIMEOUT_W  = 24;
   localparam int HALF_W     = 6;
   localparam int PULSE_W    = 5;
   localparam int SAMPLE_W   = 24;
   localparam int FRAMES_W   = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_DATA_W = 24;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd1000000;
   localparam logic [HALF_W-1:0]    HALF_RESET    = 6'd1;

endpackage

`default_nettype wire

/* sv/load_cell_adc_serial_reader.sv */
// Top level of the load cell converter serial reader.
// Depends on lcasr_pkg.
`default_nettype none

// Each request is one time tick carrying a start flag and the converter data
// line level; each request yields exactly one response carrying the clock
// level to drive, a done flag, status, sample and the completed-frame count.
// A request is taken every cycle while the response register is empty or
// being drained, so the sustained rate is one request per clock; the state
// update and response are formed in one pass between the request and the
// response register. A readout lasts 1 start tick, the wait for data low, and
// PULSES_PER_FRAME pulses of 2*half_period_ticks ticks each (0 counts as 1).
// Registers: index 0 timeout_limit, index 1 half_period_ticks.
module load_cell_adc_serial_reader #(
   parameter int DATA_BITS        = 24,
   parameter int PULSES_PER_FRAME = 25
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // [0] start_req, [1] dout_level, [7:2] zero
   input  wire  [lcasr_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // [0] sck_level, [1] done_res, [3:2] status, [27:4] sample,
   // [43:28] frames_read, [47:44] zero
   output logic [lcasr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire                              csr_we,
   input  wire                              csr_addr,
   input  wire  [lcasr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lcasr_pkg::*;

   localparam int ExtW = (DATA_BITS > SAMPLE_W) ? DATA_BITS : SAMPLE_W;
   localparam logic [DATA_BITS-1:0] MaxCode = {1'b0, {(DATA_BITS-1){1'b1}}};
   localparam logic [DATA_BITS-1:0] MinCode = {1'b1, {(DATA_BITS-1){1'b0}}};

   logic [TIMEOUT_W-1:0] timeout_limit_ff;
   logic [HALF_W-1:0]    half_period_ff;

   phase_type            phase_ff, phase_in;
   logic [TIMEOUT_W-1:0] wait_count_ff, wait_count_in;
   logic [PULSE_W-1:0]   pulse_index_ff, pulse_index_in;
   logic [HALF_W-1:0]    phase_timer_ff, phase_timer_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [FRAMES_W-1:0]  frame_count_ff, frame_count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 sck_ff, sck_in;
   logic                 done_ff, done_in;
   logic [1:0]           status_ff, status_in;
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [FRAMES_W-1:0]  frames_ff;

   logic                 start_req, dout_level, accept;
   logic [HALF_W-1:0]    half_period;
   logic [HALF_W-1:0]    timer_inc;
   logic [PULSE_W-1:0]   pulse_inc;
   logic signed [DATA_BITS-1:0] shift_s;
   logic signed [ExtW-1:0]      shift_ext;

   assign start_req  = req_tdata[0];
   assign dout_level = req_tdata[1];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign half_period = (half_period_ff == '0) ? HALF_W'(1) : half_period_ff;
   assign timer_inc   = phase_timer_ff + HALF_W'(1);
   assign pulse_inc   = pulse_index_ff + PULSE_W'(1);
   assign shift_s     = shift_ff;
   assign shift_ext   = ExtW'(shift_s);

   always_comb begin
      phase_in       = phase_ff;
      wait_count_in  = wait_count_ff;
      pulse_index_in = pulse_index_ff;
      phase_timer_in = phase_timer_ff;
      shift_in       = shift_ff;
      frame_count_in = frame_count_ff;
      sck_in         = 1'b0;
      done_in        = 1'b0;
      status_in      = ST_OK;
      sample_in      = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               phase_in      = PH_WAIT;
               wait_count_in = '0;
            end
         end
         PH_WAIT: begin
            if (!dout_level) begin
               phase_in       = PH_HIGH;
               phase_timer_in = '0;
               pulse_index_in = '0;
               shift_in       = '0;
            end else if (wait_count_ff >= timeout_limit_ff) begin
               phase_in  = PH_IDLE;
               done_in   = 1'b1;
               status_in = ST_TIMEOUT;
            end else begin
               wait_count_in = wait_count_ff + TIMEOUT_W'(1);
            end
         end
         PH_HIGH: begin
            sck_in         = 1'b1;
            phase_timer_in = timer_inc;
            if (timer_inc >= half_period) begin
               // sample on the last tick of the high phase, MSB first
               if ({1'b0, pulse_index_ff} < 6'(DATA_BITS))
                  shift_in = {shift_ff[DATA_BITS-2:0], dout_level};
               phase_in       = PH_LOW;
               phase_timer_in = '0;
            end
         end
         PH_LOW: begin
            phase_timer_in = timer_inc;
            if (timer_inc >= half_period) begin
               phase_timer_in = '0;
               pulse_index_in = pulse_inc;
               if (pulse_inc >= PULSE_W'(PULSES_PER_FRAME)) begin
                  phase_in       = PH_IDLE;
                  pulse_index_in = '0;
                  done_in        = 1'b1;
                  if (frame_count_ff != '1)
                     frame_count_in = frame_count_ff + FRAMES_W'(1);
                  status_in = (shift_ff == MaxCode || shift_ff == MinCode) ? ST_SAT
                                                                          : ST_OK;
                  sample_in = shift_ext[SAMPLE_W-1:0];
               end else begin
                  phase_in = PH_HIGH;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_limit_ff <= TIMEOUT_RESET;
         half_period_ff   <= HALF_RESET;
         phase_ff         <= PH_IDLE;
         wait_count_ff    <= '0;
         pulse_index_ff   <= '0;
         phase_timer_ff   <= '0;
         shift_ff         <= '0;
         frame_count_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_TIMEOUT_LIMIT: timeout_limit_ff <= csr_wdata[TIMEOUT_W-1:0];
               CSR_HALF_PERIOD:   half_period_ff   <= csr_wdata[HALF_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff       <= phase_in;
            wait_count_ff  <= wait_count_in;
            pulse_index_ff <= pulse_index_in;
            phase_timer_ff <= phase_timer_in;
            shift_ff       <= shift_in;
            frame_count_ff <= frame_count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded with each accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         sck_ff    <= sck_in;
         done_ff   <= done_in;
         status_ff <= status_in;
         sample_ff <= sample_in;
         frames_ff <= frame_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, frames_ff, sample_ff, status_ff, done_ff, sck_ff};

   // the response register always follows an accepted request
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted request left no response");

   // a finished readout never drives the clock line high
   a_done_sck_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> !sck_ff)
      else $error("done reported with clock high");

   // a timeout carries no sample, a completed frame counts at least once
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff && status_ff == ST_TIMEOUT) |-> sample_ff == '0)
      else $error("timeout with non-zero sample");

   a_frame_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff && status_ff != ST_TIMEOUT) |-> frames_ff != '0)
      else $error("completed frame not counted");

endmodule

`default_nettype wire
